@@ design/fdl_pkg.sv @@
// fdl_pkg: shared types and constants for the feedback delay line
// holds the sequencer states, register indexes and divide-by-constant reciprocals
// no dependencies
package fdl_pkg;

    localparam int unsigned DEPTH_DEFAULT  = 131072;
    localparam int unsigned MAX_MS_DEFAULT = 1000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_BASE,
        CFG_DELAY_CV,
        CFG_FB_BASE,
        CFG_FB_CV,
        CFG_MIX_BASE,
        CFG_MIX_CV,
        CFG_RATE
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_PART,
        ST_SCALE,
        ST_RECIP,
        ST_ADDR,
        ST_READ,
        ST_PROD,
        ST_ACC,
        ST_DIV,
        ST_DONE
    } t_state;

    // floor(v / 625) = (v * D_RECIP) >> D_SHIFT for v below 2^30
    localparam int          D_SHIFT = 40;
    localparam logic [30:0] D_RECIP = 31'(((64'd1 << D_SHIFT) + 64'd624) / 64'd625);

    // floor(v / 5) = (v * W_RECIP) >> W_SHIFT for v below 2^26
    localparam int          W_SHIFT = 26;
    localparam logic [23:0] W_RECIP = 24'(((64'd1 << W_SHIFT) + 64'd4) / 64'd5);

    localparam logic [14:0] MIX_BASE_RESET = 15'd8192;
    localparam logic [16:0] RATE_RESET     = 17'd44100;

endpackage

@@ design/feedback_delay_line_top.sv @@
// feedback_delay_line_top: feedback echo with wet/dry mix over one sample memory
// depends on fdl_pkg
// o_in_ready is high only in idle: a new input beat is taken once the last result is
// handed over, as the single-item sequencer runs delay scaling multiplies, the memory
// read and the divide-by-five step one after another for each sample
// reset (sync, active low) restores register defaults, write slot and fill flag;
// memory entries not written since reset read as zero through the fill flag, no sweep
module feedback_delay_line_top #(
    parameter int unsigned DELAY_DEPTH  = fdl_pkg::DEPTH_DEFAULT,
    parameter int unsigned MAX_DELAY_MS = fdl_pkg::MAX_MS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fdl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fdl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [15:0]              i_audio_in,
    input  logic signed [15:0]              i_delay_mod,
    input  logic signed [15:0]              i_feedback_mod,
    input  logic signed [15:0]              i_mix_mod,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [15:0]              o_audio_out
);

    localparam int AW  = $clog2(DELAY_DEPTH);
    localparam int MW  = $clog2(MAX_DELAY_MS + 1);
    localparam int MSW = ((31 + MW > 40) ? 31 + MW : 40) + 1;
    localparam int MHW = MSW - 25;
    localparam int TW  = (MSW + 16 > 60) ? MSW + 16 : 60;

    localparam logic signed [MW:0] MAX_S     = (MW + 1)'(MAX_DELAY_MS);
    localparam logic [AW-1:0]      DEPTH_AW  = AW'(DELAY_DEPTH);
    localparam logic [AW-1:0]      LAST_SLOT = AW'(DELAY_DEPTH - 1);

    // configuration
    logic [9:0]         r_delay_base;
    logic signed [15:0] r_delay_cv_gain;
    logic signed [15:0] r_fb_base;
    logic signed [15:0] r_fb_cv_gain;
    logic [14:0]        r_mix_base;
    logic signed [15:0] r_mix_cv_gain;
    logic [16:0]        r_sample_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_base    <= '0;
            r_delay_cv_gain <= '0;
            r_fb_base       <= '0;
            r_fb_cv_gain    <= '0;
            r_mix_base      <= fdl_pkg::MIX_BASE_RESET;
            r_mix_cv_gain   <= '0;
            r_sample_rate   <= fdl_pkg::RATE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fdl_pkg::CFG_DELAY_BASE: r_delay_base    <= i_cfg_data[9:0];
                fdl_pkg::CFG_DELAY_CV:   r_delay_cv_gain <= i_cfg_data[15:0];
                fdl_pkg::CFG_FB_BASE:    r_fb_base       <= i_cfg_data[15:0];
                fdl_pkg::CFG_FB_CV:      r_fb_cv_gain    <= i_cfg_data[15:0];
                fdl_pkg::CFG_MIX_BASE:   r_mix_base      <= i_cfg_data[14:0];
                fdl_pkg::CFG_MIX_CV:     r_mix_cv_gain   <= i_cfg_data[15:0];
                fdl_pkg::CFG_RATE:       r_sample_rate   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // sequencer
    fdl_pkg::t_state r_state;
    fdl_pkg::t_state n_state;
    logic            out_free;
    logic            finish;

    assign out_free = !o_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        finish     = 1'b0;
        unique case (r_state)
            fdl_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) n_state = fdl_pkg::ST_MUL;
            end
            fdl_pkg::ST_MUL:   n_state = fdl_pkg::ST_SUM;
            fdl_pkg::ST_SUM:   n_state = fdl_pkg::ST_PART;
            fdl_pkg::ST_PART:  n_state = fdl_pkg::ST_SCALE;
            fdl_pkg::ST_SCALE: n_state = fdl_pkg::ST_RECIP;
            fdl_pkg::ST_RECIP: n_state = fdl_pkg::ST_ADDR;
            fdl_pkg::ST_ADDR:  n_state = fdl_pkg::ST_READ;
            fdl_pkg::ST_READ:  n_state = fdl_pkg::ST_PROD;
            fdl_pkg::ST_PROD:  n_state = fdl_pkg::ST_ACC;
            fdl_pkg::ST_ACC:   n_state = fdl_pkg::ST_DIV;
            fdl_pkg::ST_DIV:   n_state = fdl_pkg::ST_DONE;
            fdl_pkg::ST_DONE: begin
                if (out_free) begin
                    finish  = 1'b1;
                    n_state = fdl_pkg::ST_IDLE;
                end
            end
            default: n_state = fdl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    logic signed [15:0]    r_x;
    logic signed [15:0]    r_dmod;
    logic signed [15:0]    r_fmod;
    logic signed [15:0]    r_mmod;
    logic signed [31:0]    r_dprod;
    logic signed [31:0]    r_fprod;
    logic signed [31:0]    r_mprod;
    logic signed [MSW-1:0] r_ms;
    logic signed [31:0]    r_fbn;
    logic signed [31:0]    r_mixn;
    logic [40:0]           r_pl;
    logic [MHW+16:0]       r_ph;
    logic                  r_ms_neg;
    logic [29:0]           r_v;
    logic                  r_big;
    logic [60:0]           r_q;
    logic [AW-1:0]         r_rd_addr;
    logic                  r_rd_valid;
    logic [15:0]           r_mem_q;
    logic signed [47:0]    r_pf;
    logic signed [48:0]    r_pm;
    logic [22:0]           r_wq;
    logic                  r_wneg;
    logic signed [15:0]    r_y;
    logic [46:0]           r_wdq;

    // delay scaling
    logic [13:0]           base_x10;
    logic signed [MSW-1:0] n_ms;
    logic signed [31:0]    n_fbn;
    logic signed [31:0]    n_mixn;
    logic [TW-1:0]         n_t;

    assign base_x10 = 14'(r_delay_base) * 14'd10;
    assign n_ms     = MSW'(MAX_S) * MSW'(r_dprod)
                    + $signed({{(MSW-39){1'b0}}, base_x10, 25'b0});
    assign n_fbn    = 32'(r_fb_base) * 32'sd10240 + r_fprod;
    assign n_mixn   = $signed({6'b0, r_mix_base, 11'b0}) + r_mprod;
    assign n_t      = (TW'(r_ph) << 24) + TW'(r_pl);

    // delay in samples and read slot
    logic [20:0]   q_d;
    logic [AW-1:0] d_samp;
    logic [AW-1:0] r_pos;
    logic          r_wrapped;
    logic          pos_ge_d;

    assign q_d = r_q[60:fdl_pkg::D_SHIFT];

    always_comb begin
        if (r_ms_neg || q_d == '0) begin
            d_samp = AW'(1);
        end else if (r_big || {11'b0, q_d} >= 32'(DELAY_DEPTH)) begin
            d_samp = LAST_SLOT;
        end else begin
            d_samp = q_d[AW-1:0];
        end
    end

    assign pos_ge_d = r_pos >= d_samp;

    // echo products and accumulation
    logic signed [15:0] delayed;
    logic signed [16:0] diff;
    logic signed [18:0] x5;
    logic signed [48:0] s_w;
    logic [48:0]        s_w_abs;
    logic signed [49:0] s_y;
    logic signed [49:0] s_y_adj;
    logic signed [24:0] y_t;
    logic signed [15:0] n_y;

    assign delayed = r_rd_valid ? $signed(r_mem_q) : 16'sd0;
    assign diff    = 17'(delayed) - 17'(r_x);
    assign x5      = 19'(r_x) * 19'sd5;
    assign s_w     = $signed({{5{x5[18]}}, x5, 25'b0}) + 49'(r_pf);
    assign s_w_abs = s_w[48] ? 49'(-s_w) : 49'(s_w);
    assign s_y     = $signed({{9{r_x[15]}}, r_x, 25'b0}) + 50'(r_pm);
    assign s_y_adj = s_y + $signed({25'b0, {25{s_y[49]}}});
    assign y_t     = s_y_adj[49:25];

    always_comb begin
        if (y_t > 25'sd32767) begin
            n_y = 16'sh7FFF;
        end else if (y_t < -25'sd32768) begin
            n_y = 16'sh8000;
        end else begin
            n_y = y_t[15:0];
        end
    end

    // written value
    logic [20:0] qw;
    logic [15:0] n_wr_data;

    assign qw = r_wdq[46:fdl_pkg::W_SHIFT];

    always_comb begin
        if (!r_wneg) begin
            n_wr_data = (qw > 21'd32767) ? 16'h7FFF : qw[15:0];
        end else begin
            n_wr_data = (qw > 21'd32768) ? 16'h8000 : 16'(~qw[15:0] + 16'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fdl_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    r_x    <= i_audio_in;
                    r_dmod <= i_delay_mod;
                    r_fmod <= i_feedback_mod;
                    r_mmod <= i_mix_mod;
                end
            end
            fdl_pkg::ST_MUL: begin
                r_dprod <= r_dmod * r_delay_cv_gain;
                r_fprod <= r_fmod * r_fb_cv_gain;
                r_mprod <= r_mmod * r_mix_cv_gain;
            end
            fdl_pkg::ST_SUM: begin
                r_ms   <= n_ms;
                r_fbn  <= n_fbn;
                r_mixn <= n_mixn;
            end
            fdl_pkg::ST_PART: begin
                r_pl     <= r_ms[23:0] * r_sample_rate;
                r_ph     <= r_ms[MSW-2:24] * r_sample_rate;
                r_ms_neg <= r_ms[MSW-1];
            end
            fdl_pkg::ST_SCALE: begin
                r_v   <= n_t[58:29];
                r_big <= |n_t[TW-1:59];
            end
            fdl_pkg::ST_RECIP: begin
                r_q <= r_v * fdl_pkg::D_RECIP;
            end
            fdl_pkg::ST_ADDR: begin
                r_rd_addr  <= r_pos - d_samp + (pos_ge_d ? AW'(0) : DEPTH_AW);
                r_rd_valid <= r_wrapped || pos_ge_d;
            end
            fdl_pkg::ST_READ: ;
            fdl_pkg::ST_PROD: begin
                r_pf <= delayed * r_fbn;
                r_pm <= diff * r_mixn;
            end
            fdl_pkg::ST_ACC: begin
                r_wq   <= s_w_abs[47:25];
                r_wneg <= s_w[48];
                r_y    <= n_y;
            end
            fdl_pkg::ST_DIV: begin
                r_wdq <= r_wq * fdl_pkg::W_RECIP;
            end
            fdl_pkg::ST_DONE: ;
            default: ;
        endcase
    end

    // echo memory
    logic [15:0] r_mem [DELAY_DEPTH];

    always_ff @(posedge i_clk) begin
        if (finish) r_mem[r_pos] <= n_wr_data;
        r_mem_q <= r_mem[r_rd_addr];
    end

    // write slot and fill flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_wrapped <= 1'b0;
        end else if (finish) begin
            if (r_pos == LAST_SLOT) begin
                r_pos     <= '0;
                r_wrapped <= 1'b1;
            end else begin
                r_pos <= r_pos + AW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (finish) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) o_audio_out <= r_y;
    end

endmodule
